FILE: hw/rtl/b1k_pkg.sv
// Shared types and constants for the base-1000 duration adder/subtractor.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package b1k_pkg;

  localparam int DigitW   = 10;
  localparam int NumDigit = 4;

  localparam logic [DigitW:0] DigitMax  = 11'd999;
  localparam logic [DigitW:0] DigitBase = DigitMax + 11'd1;

  localparam int DigitMicro = 0;
  localparam int DigitMilli = 1;
  localparam int DigitSec   = 2;
  localparam int DigitKilo  = 3;

  typedef logic [DigitW-1:0] digit_t;

  typedef struct packed {
    logic ops_ok;
    logic less;
    logic equal;
    logic greater;
  } cmp_t;

  typedef struct packed {
    logic                       sub;
    cmp_t                       cmp;
    logic [NumDigit-1:0][DigitW-1:0] a;
    logic [NumDigit-1:0][DigitW-1:0] b;
    logic [NumDigit-1:0][DigitW-1:0] r;
    logic                       cy;
  } pipe_t;

endpackage

FILE: hw/rtl/base1000_duration_add_sub_compare.sv
// Top level of the base-1000 duration adder/subtractor and comparator.
// Depends on b1k_pkg, b1k_cmp and b1k_digit.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// busy is always low, so an item may be offered in every cycle.
// The carry or borrow ripples through four pipeline stages, one digit per
// stage, from microseconds up to kiloseconds; the range check and the
// comparison are done in the first stage and travel with the item.
// out_valid is driven by the valid bit of the last stage register;
// throughput is one item per cycle, set
// by the one-digit adder in each stage.
// Each result stands on the out_ ports for exactly one cycle with out_valid
// high; the receiver cannot stall, so nothing is ever held back.
// A synchronous reset (rst_n low) clears the stage valid bits, so no result
// appears until new items arrive.
// If any operand digit is above 999 the result digits are A's and ok is low;
// a carry or borrow out of the kiloseconds digit also clears ok.
`timescale 1ns / 1ps

module base1000_duration_add_sub_compare (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic            in_action,
  input  b1k_pkg::digit_t in_a_kilo,
  input  b1k_pkg::digit_t in_a_sec,
  input  b1k_pkg::digit_t in_a_milli,
  input  b1k_pkg::digit_t in_a_micro,
  input  b1k_pkg::digit_t in_b_kilo,
  input  b1k_pkg::digit_t in_b_sec,
  input  b1k_pkg::digit_t in_b_milli,
  input  b1k_pkg::digit_t in_b_micro,
  output logic            out_valid,
  output b1k_pkg::digit_t out_r_kilo,
  output b1k_pkg::digit_t out_r_sec,
  output b1k_pkg::digit_t out_r_milli,
  output b1k_pkg::digit_t out_r_micro,
  output logic            out_ok,
  output logic            out_a_less,
  output logic            out_a_equal,
  output logic            out_a_greater
);
  import b1k_pkg::*;

  logic [NumDigit-1:0][DigitW-1:0] in_a;
  logic [NumDigit-1:0][DigitW-1:0] in_b;
  cmp_t                            in_cmp;
  pipe_t                           entry;
  logic                            accept;

  pipe_t                           stg_in   [NumDigit];
  pipe_t                           pipe_nxt [NumDigit];
  pipe_t                           pipe_r   [NumDigit];
  logic  [NumDigit-1:0]            vld_in;
  logic  [NumDigit-1:0]            vld_r;
  digit_t                          dig_r    [NumDigit];
  logic  [NumDigit-1:0]            dig_c;
  pipe_t                           last;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    in_a[DigitKilo]  = in_a_kilo;
    in_a[DigitSec]   = in_a_sec;
    in_a[DigitMilli] = in_a_milli;
    in_a[DigitMicro] = in_a_micro;
    in_b[DigitKilo]  = in_b_kilo;
    in_b[DigitSec]   = in_b_sec;
    in_b[DigitMilli] = in_b_milli;
    in_b[DigitMicro] = in_b_micro;
  end

  b1k_cmp u_cmp (
    .a   (in_a),
    .b   (in_b),
    .cmp (in_cmp)
  );

  always_comb begin
    entry     = '0;
    entry.sub = in_action;
    entry.cmp = in_cmp;
    entry.a   = in_a;
    entry.b   = in_b;
    entry.cy  = 1'b0;
  end

  for (genvar i = 0; i < NumDigit; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign stg_in[i] = entry;
      assign vld_in[i] = accept;
    end else begin : g_next
      assign stg_in[i] = pipe_r[i-1];
      assign vld_in[i] = vld_r[i-1];
    end

    b1k_digit u_digit (
      .sub  (stg_in[i].sub),
      .a    (stg_in[i].a[i]),
      .b    (stg_in[i].b[i]),
      .cin  (stg_in[i].cy),
      .r    (dig_r[i]),
      .cout (dig_c[i])
    );

    always_comb begin
      pipe_nxt[i]      = stg_in[i];
      pipe_nxt[i].r[i] = dig_r[i];
      pipe_nxt[i].cy   = dig_c[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in[i];
      end
      pipe_r[i] <= pipe_nxt[i];
    end
  end

  assign last = pipe_r[NumDigit-1];

  always_comb begin
    out_valid     = vld_r[NumDigit-1];
    out_r_kilo    = last.cmp.ops_ok ? last.r[DigitKilo]  : last.a[DigitKilo];
    out_r_sec     = last.cmp.ops_ok ? last.r[DigitSec]   : last.a[DigitSec];
    out_r_milli   = last.cmp.ops_ok ? last.r[DigitMilli] : last.a[DigitMilli];
    out_r_micro   = last.cmp.ops_ok ? last.r[DigitMicro] : last.a[DigitMicro];
    out_ok        = last.cmp.ops_ok && !last.cy;
    out_a_less    = last.cmp.less;
    out_a_equal   = last.cmp.equal;
    out_a_greater = last.cmp.greater;
  end

endmodule

FILE: hw/rtl/b1k_digit.sv
// One base-1000 digit of the adder/subtractor, with carry or borrow in and out.
// Depends on b1k_pkg.
`timescale 1ns / 1ps

module b1k_digit (
  input  logic            sub,
  input  b1k_pkg::digit_t a,
  input  b1k_pkg::digit_t b,
  input  logic            cin,
  output b1k_pkg::digit_t r,
  output logic            cout
);
  import b1k_pkg::*;

  logic [DigitW:0] sum;
  logic [DigitW:0] sum_red;
  logic [DigitW:0] take;
  logic [DigitW:0] dif;
  logic            add_ovf;
  logic            borrow;

  always_comb begin
    sum     = {1'b0, a} + {1'b0, b} + {{DigitW{1'b0}}, cin};
    add_ovf = sum > DigitMax;
    sum_red = add_ovf ? (sum - DigitBase) : sum;
    take    = {1'b0, b} + {{DigitW{1'b0}}, cin};
    borrow  = {1'b0, a} < take;
    dif     = borrow ? ({1'b0, a} + DigitBase - take) : ({1'b0, a} - take);
    if (sub) begin
      r    = dif[DigitW-1:0];
      cout = borrow;
    end else begin
      r    = sum_red[DigitW-1:0];
      cout = add_ovf;
    end
  end

endmodule

FILE: hw/rtl/b1k_cmp.sv
// Operand range check and top-down digit comparison of A against B.
// Depends on b1k_pkg.
`timescale 1ns / 1ps

module b1k_cmp (
  input  logic [b1k_pkg::NumDigit-1:0][b1k_pkg::DigitW-1:0] a,
  input  logic [b1k_pkg::NumDigit-1:0][b1k_pkg::DigitW-1:0] b,
  output b1k_pkg::cmp_t                                    cmp
);
  import b1k_pkg::*;

  logic decided;

  always_comb begin
    cmp     = '0;
    decided = 1'b0;
    cmp.ops_ok = 1'b1;
    for (int i = 0; i < NumDigit; i++) begin
      if ({1'b0, a[i]} > DigitMax || {1'b0, b[i]} > DigitMax) begin
        cmp.ops_ok = 1'b0;
      end
    end
    for (int i = NumDigit - 1; i >= 0; i--) begin
      if (!decided && a[i] != b[i]) begin
        cmp.less    = a[i] < b[i];
        cmp.greater = !(a[i] < b[i]);
        decided     = 1'b1;
      end
    end
    cmp.equal = !decided;
  end

endmodule
